[design/rgbramp_pkg.sv]
`timescale 1ns / 1ps

package rgbramp_pkg;

	// PWM frame and ramp constants
	localparam int PWM_STEPS   = 240;
	localparam int RAMP_EXTRA  = 40;
	localparam int PHASE_COUNT = 7;
	localparam int RAMP_GAIN   = 2 * PHASE_COUNT * (PWM_STEPS + RAMP_EXTRA);

	localparam int DUTY_W = 8;
	localparam int TIME_W = 17;   // config registers, seconds
	localparam int TOD_W  = 18;   // time of day in seconds, from the BCD digits

	// serial divider sizes
	localparam int DIV_NW = 27;   // dividend shift register
	localparam int DIV_RW = 18;   // remainder and divisor
	localparam int DIV_QW = 17;   // quotient shift register
	localparam int DIV_CW = 5;    // iteration count
	localparam int MOD_W  = 15;   // floor(T/7)+1 and b

	localparam logic [TIME_W-1:0] START_RST  = TIME_W'(25200);
	localparam logic [TIME_W-1:0] PERIOD_RST = TIME_W'(50400);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = CFG_IDX_W'(1);

	typedef struct packed {
		logic       cmd;
		logic [1:0] hour_tens;
		logic [3:0] hour_ones;
		logic [2:0] minute_tens;
		logic [3:0] minute_ones;
		logic [2:0] second_tens;
		logic [3:0] second_ones;
	} in_beat_t;

	typedef struct packed {
		logic red_led;
		logic green_led;
		logic blue_led;
		logic clock_tick;
	} out_beat_t;

	typedef struct packed {
		logic [DUTY_W-1:0] red;
		logic [DUTY_W-1:0] green;
		logic [DUTY_W-1:0] blue;
	} duties_t;

	// levels are ordered red, green, blue from bit 0
	typedef struct packed {
		logic [2:0] lvl;
		logic [2:0] lvl_next;
		logic       wrap;
	} pwm_stat_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] dividend;   // left aligned
		logic [DIV_RW-1:0] divisor;
		logic [DIV_CW-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_QW-1:0] quo;
		logic [DIV_RW-1:0] rem;
	} div_rsp_t;

	typedef enum logic [2:0] {
		PH_RB_UP  = 3'd0,
		PH_R_B_DN = 3'd1,
		PH_R_G_UP = 3'd2,
		PH_G_R_DN = 3'd3,
		PH_G_B_UP = 3'd4,
		PH_B_G_DN = 3'd5,
		PH_B_DN   = 3'd6
	} phase_t;

endpackage

[design/rgbramp_serdiv.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module rgbramp_serdiv (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rgbramp_pkg::div_req_t req,
	output rgbramp_pkg::div_rsp_t rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [rgbramp_pkg::DIV_CW-1:0]   cnt_q;
	logic [rgbramp_pkg::DIV_NW-1:0]   num_q;
	logic [rgbramp_pkg::DIV_RW-1:0]   rem_q;
	logic [rgbramp_pkg::DIV_RW-1:0]   dvs_q;
	logic [rgbramp_pkg::DIV_QW-1:0]   quo_q;
	logic [rgbramp_pkg::DIV_RW:0]     trial;
	logic [rgbramp_pkg::DIV_RW:0]     diff;
	logic                             ge;
	logic [rgbramp_pkg::DIV_RW-1:0]   rem_nxt;

	// trial subtract of the divisor from the partial remainder
	always_comb begin
		trial   = {rem_q, num_q[rgbramp_pkg::DIV_NW-1]};
		diff    = trial - {1'b0, dvs_q};
		ge      = trial >= {1'b0, dvs_q};
		rem_nxt = ge ? diff[rgbramp_pkg::DIV_RW-1:0] : trial[rgbramp_pkg::DIV_RW-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - rgbramp_pkg::DIV_CW'(1);
				if (cnt_q == rgbramp_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nxt;
			quo_q <= {quo_q[rgbramp_pkg::DIV_QW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

[design/rgbramp_ramp.sv]
`timescale 1ns / 1ps

// Recompute sequencer: BCD time to seconds, phase and ramp level via serial divider
module rgbramp_ramp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  rgbramp_pkg::in_beat_t             digits,
	input  logic [rgbramp_pkg::TIME_W-1:0]    start_secs,
	input  logic [rgbramp_pkg::TIME_W-1:0]    period_secs,
	output logic                              busy,
	output rgbramp_pkg::duties_t              duties
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_TOD   = 8'b0000_0010,
		S_SUB   = 8'b0000_0100,
		S_DIV7  = 8'b0000_1000,
		S_MOD   = 8'b0001_0000,
		S_PHASE = 8'b0010_0000,
		S_RAMP  = 8'b0100_0000,
		S_SPARE = 8'b1000_0000
	} state_t;

	state_t                               state_q;
	logic [2:0]                           step_q;
	rgbramp_pkg::in_beat_t                dig_q;
	logic [rgbramp_pkg::TIME_W-1:0]       strt_q;
	logic [rgbramp_pkg::TIME_W-1:0]       per_q;
	logic [rgbramp_pkg::TOD_W-1:0]        acc_q;
	logic [rgbramp_pkg::TIME_W-1:0]       s_q;
	logic [rgbramp_pkg::MOD_W-1:0]        b_q;
	logic [2:0]                           k_q;
	rgbramp_pkg::duties_t                 duty_q;
	rgbramp_pkg::div_req_t                req_q;
	rgbramp_pkg::div_rsp_t                rsp;

	logic [rgbramp_pkg::TOD_W-1:0]        acc_mul;
	logic [3:0]                           dig_sel;
	logic [rgbramp_pkg::TOD_W-1:0]        s_cur;
	logic                                 in_range;
	logic [rgbramp_pkg::MOD_W-1:0]        m_nxt;
	logic [rgbramp_pkg::TIME_W+2:0]       s7m1;
	logic [rgbramp_pkg::DIV_NW-1:0]       ramp_num;
	logic [rgbramp_pkg::DUTY_W-1:0]       up;
	logic [rgbramp_pkg::DUTY_W-1:0]       down;
	logic [rgbramp_pkg::DUTY_W-1:0]       full;
	rgbramp_pkg::duties_t                 duty_nxt;

	rgbramp_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	// Horner step: acc*10 or acc*6 plus the next digit
	always_comb begin
		if (step_q[0])
			acc_mul = (acc_q << 2) + (acc_q << 1);
		else
			acc_mul = (acc_q << 3) + (acc_q << 1);
		case (step_q)
			3'd0:    dig_sel = dig_q.hour_ones;
			3'd1:    dig_sel = {1'b0, dig_q.minute_tens};
			3'd2:    dig_sel = dig_q.minute_ones;
			3'd3:    dig_sel = {1'b0, dig_q.second_tens};
			default: dig_sel = dig_q.second_ones;
		endcase
	end

	// elapsed seconds, bright period check and divider operands
	always_comb begin
		s_cur    = (acc_q > rgbramp_pkg::TOD_W'(strt_q))
			? acc_q - rgbramp_pkg::TOD_W'(strt_q) : '0;
		in_range = (s_cur != '0) && (per_q != '0)
			&& (s_cur <= rgbramp_pkg::TOD_W'(per_q));
		m_nxt    = rsp.quo[rgbramp_pkg::MOD_W-1:0] + rgbramp_pkg::MOD_W'(1);
		s7m1     = ({3'b000, s_q} << 3)
			- {3'b000, s_q} - (rgbramp_pkg::TIME_W+3)'(1);
		ramp_num = rgbramp_pkg::DIV_NW'(b_q) * rgbramp_pkg::DIV_NW'(rgbramp_pkg::RAMP_GAIN)
			+ rgbramp_pkg::DIV_NW'(per_q);
	end

	// duty selection from phase and ramp level
	always_comb begin
		full = rgbramp_pkg::DUTY_W'(rgbramp_pkg::PWM_STEPS);
		up   = (rsp.quo > rgbramp_pkg::DIV_QW'(rgbramp_pkg::PWM_STEPS))
			? full : rsp.quo[rgbramp_pkg::DUTY_W-1:0];
		down = full - up;
		duty_nxt = '0;
		case (rgbramp_pkg::phase_t'(k_q))
			rgbramp_pkg::PH_RB_UP: begin
				duty_nxt.red  = up;
				duty_nxt.blue = up;
			end
			rgbramp_pkg::PH_R_B_DN: begin
				duty_nxt.red  = full;
				duty_nxt.blue = down;
			end
			rgbramp_pkg::PH_R_G_UP: begin
				duty_nxt.red   = full;
				duty_nxt.green = up;
			end
			rgbramp_pkg::PH_G_R_DN: begin
				duty_nxt.red   = down;
				duty_nxt.green = full;
			end
			rgbramp_pkg::PH_G_B_UP: begin
				duty_nxt.green = full;
				duty_nxt.blue  = up;
			end
			rgbramp_pkg::PH_B_G_DN: begin
				duty_nxt.green = down;
				duty_nxt.blue  = full;
			end
			default: begin
				duty_nxt.blue = down;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			duty_q  <= '0;
			req_q   <= '0;
		end else begin
			req_q.start <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						step_q  <= '0;
						state_q <= S_TOD;
					end
				end
				S_TOD: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						state_q <= S_SUB;
				end
				S_SUB: begin
					if (in_range) begin
						req_q.start    <= 1'b1;
						req_q.dividend <= rgbramp_pkg::DIV_NW'(per_q)
							<< (rgbramp_pkg::DIV_NW - rgbramp_pkg::TIME_W);
						req_q.divisor  <= rgbramp_pkg::DIV_RW'(rgbramp_pkg::PHASE_COUNT);
						req_q.nbits    <= rgbramp_pkg::DIV_CW'(rgbramp_pkg::TIME_W);
						state_q        <= S_DIV7;
					end else begin
						duty_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_DIV7: begin
					if (rsp.done) begin
						req_q.start    <= 1'b1;
						req_q.dividend <= rgbramp_pkg::DIV_NW'(s_q)
							<< (rgbramp_pkg::DIV_NW - rgbramp_pkg::TIME_W);
						req_q.divisor  <= rgbramp_pkg::DIV_RW'(m_nxt);
						req_q.nbits    <= rgbramp_pkg::DIV_CW'(rgbramp_pkg::TIME_W);
						state_q        <= S_MOD;
					end
				end
				S_MOD: begin
					if (rsp.done) begin
						req_q.start    <= 1'b1;
						req_q.dividend <= rgbramp_pkg::DIV_NW'(s7m1)
							<< (rgbramp_pkg::DIV_NW - rgbramp_pkg::TIME_W - 3);
						req_q.divisor  <= rgbramp_pkg::DIV_RW'(per_q);
						req_q.nbits    <= rgbramp_pkg::DIV_CW'(rgbramp_pkg::TIME_W + 3);
						state_q        <= S_PHASE;
					end
				end
				S_PHASE: begin
					if (rsp.done) begin
						req_q.start    <= 1'b1;
						req_q.dividend <= ramp_num;
						req_q.divisor  <= {per_q, 1'b0};
						req_q.nbits    <= rgbramp_pkg::DIV_CW'(rgbramp_pkg::DIV_NW);
						state_q        <= S_RAMP;
					end
				end
				S_RAMP: begin
					if (rsp.done) begin
						duty_q  <= duty_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload captured along the way
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			dig_q  <= digits;
			strt_q <= start_secs;
			per_q  <= period_secs;
			acc_q  <= rgbramp_pkg::TOD_W'(digits.hour_tens);
		end
		if (state_q == S_TOD)
			acc_q <= acc_mul + rgbramp_pkg::TOD_W'(dig_sel);
		if (state_q == S_SUB)
			s_q <= s_cur[rgbramp_pkg::TIME_W-1:0];
		if (state_q == S_MOD && rsp.done)
			b_q <= rsp.rem[rgbramp_pkg::MOD_W-1:0];
		if (state_q == S_PHASE && rsp.done)
			k_q <= rsp.quo[2:0];
	end

	assign busy   = (state_q != S_IDLE);
	assign duties = duty_q;

endmodule

[design/rgbramp_pwm.sv]
`timescale 1ns / 1ps

// PWM frame counter and channel levels
module rgbramp_pwm (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  rgbramp_pkg::duties_t   duties,
	output rgbramp_pkg::pwm_stat_t stat
);

	logic [rgbramp_pkg::DUTY_W-1:0] count_q;
	logic [2:0]                     lvl_q;
	logic                           wrap;
	logic [rgbramp_pkg::DUTY_W-1:0] cnt_eff;
	logic [2:0]                     lvl_on;
	logic [2:0]                     lvl_nxt;
	logic [2:0][rgbramp_pkg::DUTY_W-1:0] duty;

	// wrap turns on nonzero channels, then reached duties turn off
	always_comb begin
		duty    = {duties.blue, duties.green, duties.red};
		wrap    = count_q >= rgbramp_pkg::DUTY_W'(rgbramp_pkg::PWM_STEPS);
		cnt_eff = wrap ? '0 : count_q;
		for (int i = 0; i < 3; i++) begin
			lvl_on[i]  = lvl_q[i] | (wrap && duty[i] != '0);
			lvl_nxt[i] = lvl_on[i] & ~(cnt_eff >= duty[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lvl_q   <= '0;
		end else if (fire) begin
			count_q <= cnt_eff + rgbramp_pkg::DUTY_W'(1);
			lvl_q   <= lvl_nxt;
		end
	end

	assign stat.lvl      = lvl_q;
	assign stat.lvl_next = lvl_nxt;
	assign stat.wrap     = wrap;

endmodule

[design/rgb_pwm_daylight_color_ramp.sv]
`timescale 1ns / 1ps

// Three-channel RGB PWM with a daylight color ramp. A tick beat (cmd 0) is
// taken and its result beat, the channel levels after the tick
// and the frame wrap flag, is in the output register on the next cycle. A
// recompute beat (cmd 1) returns its result beat at once (levels unchanged,
// clock_tick low) and then the block holds off input while it rebuilds the
// duties: five Horner steps turn the BCD time into seconds, then one shared
// restoring divider, one quotient bit per cycle, runs T/7, the ramp modulus,
// the phase and the ramp level (17 + 17 + 20 + 27 bit steps). When the time
// lies outside the bright period, the duties are cleared and the divider is
// not run. Configuration writes are always taken; a running recompute works
// on the register values it saw when it started.
module rgb_pwm_daylight_color_ramp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  rgbramp_pkg::in_beat_t                in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output rgbramp_pkg::out_beat_t               out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rgbramp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rgbramp_pkg::TIME_W-1:0]       cfg_data
);

	logic [rgbramp_pkg::TIME_W-1:0] start_q;
	logic [rgbramp_pkg::TIME_W-1:0] period_q;
	logic                           out_valid_q;
	rgbramp_pkg::out_beat_t         out_q;
	logic                           accept;
	logic                           ramp_busy;
	rgbramp_pkg::duties_t           duties;
	rgbramp_pkg::pwm_stat_t         pstat;

	assign cfg_ready = 1'b1;
	assign in_ready  = !ramp_busy && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;

	rgbramp_ramp u_ramp (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept && in_data.cmd),
		.digits      (in_data),
		.start_secs  (start_q),
		.period_secs (period_q),
		.busy        (ramp_busy),
		.duties      (duties)
	);

	rgbramp_pwm u_pwm (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (accept && !in_data.cmd),
		.duties (duties),
		.stat   (pstat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= rgbramp_pkg::START_RST;
			period_q <= rgbramp_pkg::PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rgbramp_pkg::CFG_START:  start_q  <= cfg_data;
				rgbramp_pkg::CFG_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_data.cmd) begin
				out_q.red_led    <= pstat.lvl[0];
				out_q.green_led  <= pstat.lvl[1];
				out_q.blue_led   <= pstat.lvl[2];
				out_q.clock_tick <= 1'b0;
			end else begin
				out_q.red_led    <= pstat.lvl_next[0];
				out_q.green_led  <= pstat.lvl_next[1];
				out_q.blue_led   <= pstat.lvl_next[2];
				out_q.clock_tick <= pstat.wrap;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("accepted beat left no result");

	a_recompute: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.cmd) |=> (ramp_busy && !out_data.clock_tick))
		else $error("recompute did not start or flagged a tick");

	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_busy |-> !in_ready)
		else $error("input taken during recompute");

	a_duty_max: assert property (@(posedge clk) disable iff (!arst_n)
		(duties.red <= rgbramp_pkg::DUTY_W'(rgbramp_pkg::PWM_STEPS))
		&& (duties.green <= rgbramp_pkg::DUTY_W'(rgbramp_pkg::PWM_STEPS))
		&& (duties.blue <= rgbramp_pkg::DUTY_W'(rgbramp_pkg::PWM_STEPS)))
		else $error("duty above frame length");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import rgbramp_pkg::*;

	localparam int SETTLE_CYCLES = 150;      // recompute busy time plus margin
	localparam int STALL_CYCLES  = 300;      // long receiver hold-off
	localparam longint WATCHDOG_NS = 64'd10_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_beat_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_beat_t            out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TIME_W-1:0]    cfg_data;

	// shadow of the block: config, PWM counter, duties, levels (bit 0 = red)
	logic [TIME_W-1:0] cfg_start;
	logic [TIME_W-1:0] cfg_period;
	logic [7:0]        pwm_cnt;
	logic [DUTY_W-1:0] duty [3];
	logic [2:0]        lvl;

	out_beat_t levels_due_q [$];

	int  err_cnt;
	int  gap_next;
	int  stall_left;
	int  hold_len;
	bit  snd_idle;
	bit  rcv_idle;

	rgb_pwm_daylight_color_ramp i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Some tests failed");
		$finish;
	end

	// rebuild the three duties from a BCD time of day
	function automatic void rebuild_duties(in_beat_t beat);
		int unsigned tod;
		int unsigned secs;
		int unsigned ramp_b;
		int unsigned up;
		int unsigned down;
		int unsigned k;
		longint unsigned t;
		longint unsigned s7;
		longint unsigned q;
		phase_t ph;
		tod = 36000 * beat.hour_tens + 3600 * beat.hour_ones + 600 * beat.minute_tens
			+ 60 * beat.minute_ones + 10 * beat.second_tens + beat.second_ones;
		secs = (tod > cfg_start) ? tod - cfg_start : 0;
		t = cfg_period;
		s7 = 64'(secs) * PHASE_COUNT;
		for (int i = 0; i < 3; i++)
			duty[i] = '0;
		// zero elapsed time, zero period and past-the-period all leave duties at 0
		if (secs != 0 && t != 0 && s7 <= PHASE_COUNT * t) begin
			ramp_b = secs % (cfg_period / PHASE_COUNT + 1);
			q = (64'(RAMP_GAIN) * ramp_b + t) / (2 * t);   // round half up
			if (q > PWM_STEPS)
				q = PWM_STEPS;
			up = 32'(q);
			down = PWM_STEPS - up;
			k = 0;
			while (k + 1 < PHASE_COUNT && s7 > (k + 1) * t)
				k++;
			ph = phase_t'(k);
			case (ph)
				PH_RB_UP: begin
					duty[0] = DUTY_W'(up);
					duty[2] = DUTY_W'(up);
				end
				PH_R_B_DN: begin
					duty[0] = DUTY_W'(PWM_STEPS);
					duty[2] = DUTY_W'(down);
				end
				PH_R_G_UP: begin
					duty[0] = DUTY_W'(PWM_STEPS);
					duty[1] = DUTY_W'(up);
				end
				PH_G_R_DN: begin
					duty[0] = DUTY_W'(down);
					duty[1] = DUTY_W'(PWM_STEPS);
				end
				PH_G_B_UP: begin
					duty[1] = DUTY_W'(PWM_STEPS);
					duty[2] = DUTY_W'(up);
				end
				PH_B_G_DN: begin
					duty[1] = DUTY_W'(down);
					duty[2] = DUTY_W'(PWM_STEPS);
				end
				default: begin
					duty[2] = DUTY_W'(down);
				end
			endcase
		end
	endfunction

	// advance the shadow by one accepted beat and queue the levels it must give
	function automatic void pwm_ramp_step(in_beat_t beat);
		out_beat_t res;
		logic wrap;
		wrap = 1'b0;
		if (beat.cmd) begin
			rebuild_duties(beat);
		end else begin
			if (pwm_cnt >= PWM_STEPS) begin
				pwm_cnt = '0;
				wrap = 1'b1;
				for (int i = 0; i < 3; i++)
					if (duty[i] != 0)
						lvl[i] = 1'b1;
			end
			for (int i = 0; i < 3; i++)
				if (pwm_cnt >= duty[i])
					lvl[i] = 1'b0;
			pwm_cnt = pwm_cnt + 8'd1;
		end
		res.red_led    = lvl[0];
		res.green_led  = lvl[1];
		res.blue_led   = lvl[2];
		res.clock_tick = wrap;
		levels_due_q.push_back(res);
	endfunction

	// recompute beat for a time of day below 144000 s (hour tens may exceed 2)
	function automatic in_beat_t clock_beat(int unsigned tod);
		in_beat_t beat;
		beat.cmd         = 1'b1;
		beat.hour_tens   = 2'(tod / 36000);
		beat.hour_ones   = 4'((tod / 3600) % 10);
		beat.minute_tens = 3'((tod % 3600) / 600);
		beat.minute_ones = 4'((tod / 60) % 10);
		beat.second_tens = 3'((tod % 60) / 10);
		beat.second_ones = 4'(tod % 10);
		return beat;
	endfunction

	// tick beat with junk in the unused time fields
	function automatic in_beat_t tick_beat();
		in_beat_t beat;
		logic [31:0] r;
		r = $urandom;
		beat = r[$bits(in_beat_t)-1:0];
		beat.cmd = 1'b0;
		return beat;
	endfunction

	// mostly times inside the bright period, some near phase edges, some random times of day, some raw digits
	function automatic in_beat_t ramp_beat();
		in_beat_t beat;
		logic [31:0] r;
		int unsigned sel;
		int unsigned secs;
		int unsigned tod;
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			if (sel < 3)
				secs = ($urandom_range(0, 7) * cfg_period) / 7 + $urandom_range(0, 2);
			else
				secs = $urandom_range(0, cfg_period + cfg_period / 8 + 2);
			tod = cfg_start + secs;
			if (tod >= 144000)
				tod = $urandom_range(0, 143999);
			beat = clock_beat(tod);
		end else if (sel < 16) begin
			beat = clock_beat($urandom_range(0, 86399));
		end else begin
			r = $urandom;
			beat = r[$bits(in_beat_t)-1:0];
			beat.cmd = 1'b1;
		end
		return beat;
	endfunction

	// offer one beat, hold it until taken, then predict
	task automatic send_item(input in_beat_t beat);
		repeat (gap_next) @(posedge clk);
		in_valid <= 1'b1;
		in_data  <= beat;
		do @(posedge clk); while (!in_ready);
		pwm_ramp_step(beat);
		gap_next = snd_idle ? $urandom_range(0, 4) : 0;
		if (gap_next != 0)
			in_valid <= 1'b0;
	endtask

	// stop offering, wait for all results, then let a recompute finish
	task automatic wait_idle();
		if (gap_next == 0)
			in_valid <= 1'b0;
		gap_next = 0;
		while (levels_due_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back, valid held across the two beats
	task automatic set_config(input int unsigned start, input int unsigned period);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= CFG_START;
		cfg_data  <= TIME_W'(start);
		do @(posedge clk); while (!cfg_ready);
		cfg_start = TIME_W'(start);
		cfg_index <= CFG_PERIOD;
		cfg_data  <= TIME_W'(period);
		do @(posedge clk); while (!cfg_ready);
		cfg_period = TIME_W'(period);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int n);
		in_beat_t beat;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 24) == 0)
				beat = ramp_beat();
			else
				beat = tick_beat();
			send_item(beat);
		end
	endtask

	// phase edges at reset config, zero and all-ones digits
	task automatic test_directed_ramp();
		int unsigned ramp_points [11] = '{0, 1, 7200, 7201, 14401, 21601, 28801,
			36001, 43201, 50400, 50401};
		in_beat_t beat;
		snd_idle = 1'b1;
		rcv_idle = 1'b1;
		send_item(tick_beat());
		beat = '0;
		beat.cmd = 1'b1;
		send_item(beat);
		beat = '1;
		send_item(beat);
		send_item(tick_beat());
		foreach (ramp_points[i]) begin
			send_item(clock_beat(cfg_start + ramp_points[i]));
			send_item(tick_beat());
		end
	endtask

	// register extremes, including a zero period and full-width values
	task automatic test_config_extremes();
		snd_idle = 1'b0;
		rcv_idle = 1'b0;
		run_random(300);
		snd_idle = 1'b1;
		rcv_idle = 1'b1;
		set_config(0, 7);
		run_random(250);
		set_config(86399, 86400);
		run_random(250);
		set_config(25200, 0);
		run_random(150);
		set_config(131071, 131071);
		run_random(150);
	endtask

	task automatic test_random_config();
		for (int p = 0; p < 3; p++) begin
			if (p == 1)
				set_config($urandom_range(0, 86399), $urandom_range(7, 40));
			else
				set_config($urandom_range(0, 86399), $urandom_range(7, 86400));
			snd_idle = (p != 2);
			rcv_idle = (p != 0);
			run_random(200);
		end
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_output_stall();
		set_config(25200, 50400);
		snd_idle = 1'b1;
		rcv_idle = 1'b1;
		hold_len = STALL_CYCLES;
		run_random(100);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_START;
		cfg_data  = '0;
		cfg_start  = START_RST;
		cfg_period = PERIOD_RST;
		pwm_cnt = '0;
		lvl = '0;
		for (int i = 0; i < 3; i++)
			duty[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ramp();
		test_config_extremes();
		test_random_config();
		test_output_stall();

		wait_idle();
		if (err_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side: compare each taken beat with the oldest prediction
	initial begin : result_monitor
		out_beat_t want;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (levels_due_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result beat %b", out_data);
				end else begin
					want = levels_due_q.pop_front();
					if (want.red_led !== out_data.red_led
							|| want.green_led !== out_data.green_led
							|| want.blue_led !== out_data.blue_led
							|| want.clock_tick !== out_data.clock_tick) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch (r g b tick): expected %b actual %b",
								want, out_data);
					end
				end
				stall_left = rcv_idle ? $urandom_range(0, 4) : 0;
			end
			if (hold_len != 0) begin
				stall_left = hold_len;
				hold_len = 0;
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

endmodule
